>>> hw/rtl/lsms_pkg.sv
// ----------------------------------------------------------------------------
// lsms_pkg
// Shared widths, opcodes, reset values and types of the LED and switch
// matrix scanner.
// ----------------------------------------------------------------------------
package lsms_pkg;

   localparam int ROW_BITS    = 3;
   localparam int TICK_BITS   = 16;
   localparam int OPCODE_BITS = 2;
   localparam int READ_BITS   = 36;
   localparam int LEVEL_BITS  = 18;
   localparam int BLANK_BITS  = 15;
   localparam int SETTLE_BITS = 13;

   localparam logic [OPCODE_BITS-1:0] OP_TICK     = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_WRITE    = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_READ_ROW = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_READ_REG = 2'd3;

   localparam logic [TICK_BITS-1:0]   LIT_TICKS_RESET    = 16'd50;
   localparam logic [BLANK_BITS-1:0]  BLANK_TICKS_RESET  = 15'(LIT_TICKS_RESET / 2);
   localparam logic [SETTLE_BITS-1:0] SETTLE_TICKS_RESET = 13'(LIT_TICKS_RESET / 10);

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
   localparam logic [16:0] DIV10_MUL   = 17'h0CCCD;
   localparam int          DIV10_SHIFT = 19;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_address;
      logic                led_enable;
      logic                columns_drive;
      logic                latch_row;
      logic                sample_switch;
   } scan_info_type;

endpackage

>>> hw/rtl/lsms_req_if.sv
// ----------------------------------------------------------------------------
// lsms_req_if
// Request channel: tick, masked LED row write and switch reads.
// ----------------------------------------------------------------------------
interface lsms_req_if #(
   parameter int COLUMNS = 18
);
   logic                                valid;
   logic                                ready;
   logic [lsms_pkg::OPCODE_BITS-1:0]    opcode;
   logic [lsms_pkg::ROW_BITS-1:0]       row_index;
   logic [COLUMNS-1:0]                  write_data;
   logic [COLUMNS-1:0]                  write_mask;
   logic [COLUMNS-1:0]                  column_sense;

   modport source (output valid, opcode, row_index, write_data, write_mask, column_sense,
                   input ready);
   modport sink   (input valid, opcode, row_index, write_data, write_mask, column_sense,
                   output ready);
endinterface

>>> hw/rtl/lsms_rsp_if.sv
// ----------------------------------------------------------------------------
// lsms_rsp_if
// Response channel: panel pin state and read data, one per transaction.
// ----------------------------------------------------------------------------
interface lsms_rsp_if #(
   parameter int COLUMNS = 18
);
   logic                               valid;
   logic                               ready;
   logic [lsms_pkg::ROW_BITS-1:0]      row_address;
   logic                               led_enable;
   logic                               columns_drive;
   logic [COLUMNS-1:0]                 column_level;
   logic [lsms_pkg::READ_BITS-1:0]     read_data;

   modport source (output valid, row_address, led_enable, columns_drive, column_level,
                   read_data, input ready);
   modport sink   (input valid, row_address, led_enable, columns_drive, column_level,
                   read_data, output ready);
endinterface

>>> hw/rtl/lsms_csr_if.sv
// ----------------------------------------------------------------------------
// lsms_csr_if
// Configuration write channel for lit_ticks.
// ----------------------------------------------------------------------------
interface lsms_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lsms_pkg::TICK_BITS-1:0]   lit_ticks;

   modport source (output valid, lit_ticks, input ready);
   modport sink   (input valid, lit_ticks, output ready);
endinterface

>>> hw/rtl/lsms_row_mem.sv
// ----------------------------------------------------------------------------
// lsms_row_mem
// Row memory, one write and one registered read port, per-entry valid bits
// for the reset value and write-to-read forwarding on a same-entry collision.
// ----------------------------------------------------------------------------
module lsms_row_mem #(
   parameter int               DEPTH       = 8,
   parameter int               WIDTH       = 18,
   parameter int               AW          = 3,
   parameter logic [WIDTH-1:0] RESET_VALUE = '0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic             rvalid_ff;
   logic [WIDTH-1:0] byp_data_ff;
   logic             byp_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff    <= mem_ff[rd_addr];
         rvalid_ff   <= valid_ff[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         byp_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            byp_hit_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : (rvalid_ff ? rdata_ff : RESET_VALUE);

`ifndef NO_ASSERTIONS
   a_forward: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en && (rd_addr == wr_addr)) |=> (rd_data == $past(wr_data)))
      else $error("same-entry write not forwarded to read");
`endif

endmodule

>>> hw/rtl/lsms_scan_ctrl.sv
// ----------------------------------------------------------------------------
// lsms_scan_ctrl
// Scan sequencer: lit, blank and switch phases, row and tick counters, and
// the lit_ticks register with its derived blank and settle lengths.
// ----------------------------------------------------------------------------
module lsms_scan_ctrl #(
   parameter int LED_ROWS    = 7,
   parameter int SWITCH_ROWS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cfg_wr,
   input  logic [lsms_pkg::TICK_BITS-1:0] cfg_data,
   input  logic                           advance,
   output lsms_pkg::scan_info_type        info
);

   localparam logic [1:0] PH_LIT    = 2'd0;
   localparam logic [1:0] PH_BLANK  = 2'd1;
   localparam logic [1:0] PH_SWITCH = 2'd2;

   localparam int TB = lsms_pkg::TICK_BITS;

   logic [1:0]                         phase_ff, phase_in;
   logic [lsms_pkg::ROW_BITS-1:0]      row_ff, row_in;
   logic [TB-1:0]                      count_ff, count_in;
   logic [TB-1:0]                      lit_len_ff;
   logic [lsms_pkg::BLANK_BITS-1:0]    blank_ff;
   logic [lsms_pkg::SETTLE_BITS-1:0]   settle_ff;

   logic [32:0]                        cfg_prod;
   logic [TB:0]                        count_inc;
   logic [lsms_pkg::ROW_BITS-1:0]      row_inc;
   logic                               led_last;
   logic                               sw_last;
   logic                               settled;

   assign cfg_prod  = {17'd0, cfg_data} * {16'd0, lsms_pkg::DIV10_MUL};
   assign count_inc = {1'b0, count_ff} + 17'd1;
   assign row_inc   = row_ff + 3'd1;
   assign led_last  = ({1'b0, row_inc} >= 4'(LED_ROWS)) || (row_inc == 3'd0);
   assign sw_last   = ({1'b0, row_inc} >= 4'(SWITCH_ROWS)) || (row_inc == 3'd0);
   assign settled   = count_ff >= TB'(settle_ff);

   always_comb begin
      phase_in = phase_ff;
      row_in   = row_ff;
      count_in = count_ff;
      case (phase_ff)
         PH_LIT: begin
            if (count_inc >= {1'b0, lit_len_ff}) begin
               count_in = '0;
               if (blank_ff != '0) begin
                  phase_in = PH_BLANK;
               end else begin
                  phase_in = led_last ? PH_SWITCH : PH_LIT;
                  row_in   = led_last ? 3'd0 : row_inc;
               end
            end else begin
               count_in = count_inc[TB-1:0];
            end
         end
         PH_BLANK: begin
            if (count_inc >= (TB+1)'(blank_ff)) begin
               count_in = '0;
               phase_in = led_last ? PH_SWITCH : PH_LIT;
               row_in   = led_last ? 3'd0 : row_inc;
            end else begin
               count_in = count_inc[TB-1:0];
            end
         end
         PH_SWITCH: begin
            if (settled) begin
               count_in = '0;
               row_in   = sw_last ? 3'd0 : row_inc;
               phase_in = sw_last ? PH_LIT : PH_SWITCH;
            end else begin
               count_in = count_inc[TB-1:0];
            end
         end
         default: begin
            phase_in = PH_LIT;
            row_in   = '0;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LIT;
         row_ff     <= '0;
         count_ff   <= '0;
         lit_len_ff <= lsms_pkg::LIT_TICKS_RESET;
         blank_ff   <= lsms_pkg::BLANK_TICKS_RESET;
         settle_ff  <= lsms_pkg::SETTLE_TICKS_RESET;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
            row_ff   <= row_in;
            count_ff <= count_in;
         end
         if (cfg_wr) begin
            lit_len_ff <= (cfg_data == '0) ? TB'(1) : cfg_data;
            blank_ff   <= cfg_data[TB-1:1];
            settle_ff  <= cfg_prod[lsms_pkg::DIV10_SHIFT +: lsms_pkg::SETTLE_BITS];
         end
      end
   end

   always_comb begin
      info.row_address   = row_ff;
      info.led_enable    = (phase_ff == PH_LIT);
      info.columns_drive = (phase_ff == PH_LIT) || (phase_ff == PH_BLANK);
      info.latch_row     = (phase_ff == PH_LIT) && (count_ff == '0) &&
                           ({1'b0, row_ff} < 4'(LED_ROWS));
      info.sample_switch = (phase_ff == PH_SWITCH) && settled &&
                           ({1'b0, row_ff} < 4'(SWITCH_ROWS));
   end

`ifndef NO_ASSERTIONS
   a_switch_row: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SWITCH) |-> ({1'b0, row_ff} < 4'(SWITCH_ROWS)))
      else $error("switch phase on missing row");
   a_led_row: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_LIT) || (phase_ff == PH_BLANK)) |-> ({1'b0, row_ff} < 4'(LED_ROWS)))
      else $error("LED phase on missing row");
   a_phase_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != $past(phase_ff)) |-> (count_ff == '0))
      else $error("phase change without tick count clear");
`endif

endmodule

>>> hw/rtl/led_switch_matrix_scanner.sv
// ----------------------------------------------------------------------------
// led_switch_matrix_scanner
// Pipeline: stage register and LED row read at acceptance; response register
// and masked LED row write at commit, forwarded. Throughput: one transaction
// per cycle unless the response stalls, set by that read-modify-write.
// Reset: synchronous; LED rows read zero and switch rows all ones through
// per-entry valid bits, no clearing pass; lit_ticks returns to 50.
// ----------------------------------------------------------------------------
module led_switch_matrix_scanner #(
   parameter int LED_ROWS    = 7,
   parameter int SWITCH_ROWS = 5,
   parameter int COLUMNS     = 18
) (
   input  logic         clock,
   input  logic         reset,
   lsms_req_if.sink     req_bus,
   lsms_rsp_if.source   rsp_bus,
   lsms_csr_if.sink     csr_bus
);

   localparam int LED_AW = (LED_ROWS > 1) ? $clog2(LED_ROWS) : 1;
   localparam int SW_AW  = (SWITCH_ROWS > 1) ? $clog2(SWITCH_ROWS) : 1;
   localparam int RB     = lsms_pkg::ROW_BITS;

   typedef struct packed {
      logic [lsms_pkg::OPCODE_BITS-1:0] opcode;
      logic [RB-1:0]                    row_index;
      logic [COLUMNS-1:0]               write_data;
      logic [COLUMNS-1:0]               write_mask;
      logic [RB-1:0]                    row_address;
      logic                             led_enable;
      logic                             columns_drive;
      logic                             latch_row;
   } stage_type;

   lsms_pkg::scan_info_type info;

   logic                       accept;
   logic                       commit;
   logic                       is_tick;
   logic                       is_write;
   logic                       is_read;

   stage_type                  s1_ff, s1_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic [COLUMNS-1:0]         latched_ff, latched_in;

   logic                       led_rd_en;
   logic [LED_AW-1:0]          led_rd_addr;
   logic [COLUMNS-1:0]         led_old;
   logic                       led_wr_en;
   logic [COLUMNS-1:0]         led_wr_data;

   logic                       sw_rd_en;
   logic [SW_AW-1:0]           sw_lo_addr;
   logic [COLUMNS-1:0]         sw_lo;
   logic [COLUMNS-1:0]         sw_hi;
   logic                       sw_wr_en;

   logic [COLUMNS-1:0]         level_val;
   logic [COLUMNS-1:0]         level_out;
   logic [63:0]                pair_wide;
   logic [lsms_pkg::READ_BITS-1:0] read_out;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RB-1:0]              rsp_row_ff;
   logic                       rsp_led_en_ff;
   logic                       rsp_drive_ff;
   logic [COLUMNS-1:0]         rsp_level_ff;
   logic [lsms_pkg::READ_BITS-1:0] rsp_read_ff;

   assign commit          = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !s1_valid_ff || commit;
   assign accept          = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;

   assign is_tick  = (req_bus.opcode == lsms_pkg::OP_TICK);
   assign is_write = (req_bus.opcode == lsms_pkg::OP_WRITE);
   assign is_read  = (req_bus.opcode == lsms_pkg::OP_READ_ROW) ||
                     (req_bus.opcode == lsms_pkg::OP_READ_REG);

   lsms_scan_ctrl #(
      .LED_ROWS    (LED_ROWS),
      .SWITCH_ROWS (SWITCH_ROWS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .cfg_wr   (csr_bus.valid),
      .cfg_data (csr_bus.lit_ticks),
      .advance  (accept && is_tick),
      .info     (info)
   );

   // LED rows: read at acceptance, masked write-back when the stage commits
   assign led_rd_en   = accept && (is_write || (is_tick && info.latch_row));
   assign led_rd_addr = is_write ? req_bus.row_index[LED_AW-1:0]
                                 : info.row_address[LED_AW-1:0];
   assign led_wr_en   = commit && (s1_ff.opcode == lsms_pkg::OP_WRITE) &&
                        ({1'b0, s1_ff.row_index} < 4'(LED_ROWS));
   assign led_wr_data = (led_old & ~s1_ff.write_mask) | (s1_ff.write_data & s1_ff.write_mask);

   lsms_row_mem #(
      .DEPTH       (LED_ROWS),
      .WIDTH       (COLUMNS),
      .AW          (LED_AW),
      .RESET_VALUE ('0)
   ) u_led_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (led_rd_en),
      .rd_addr (led_rd_addr),
      .rd_data (led_old),
      .wr_en   (led_wr_en),
      .wr_addr (s1_ff.row_index[LED_AW-1:0]),
      .wr_data (led_wr_data)
   );

   // Switch rows: two copies give the second read port of the register read
   assign sw_wr_en   = accept && is_tick && info.sample_switch;
   assign sw_rd_en   = accept && is_read;
   assign sw_lo_addr = (req_bus.opcode == lsms_pkg::OP_READ_REG) ? SW_AW'(0)
                                                                : req_bus.row_index[SW_AW-1:0];

   lsms_row_mem #(
      .DEPTH       (SWITCH_ROWS),
      .WIDTH       (COLUMNS),
      .AW          (SW_AW),
      .RESET_VALUE ('1)
   ) u_sw_mem_lo (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (sw_rd_en),
      .rd_addr (sw_lo_addr),
      .rd_data (sw_lo),
      .wr_en   (sw_wr_en),
      .wr_addr (info.row_address[SW_AW-1:0]),
      .wr_data (req_bus.column_sense)
   );

   lsms_row_mem #(
      .DEPTH       (SWITCH_ROWS),
      .WIDTH       (COLUMNS),
      .AW          (SW_AW),
      .RESET_VALUE ('1)
   ) u_sw_mem_hi (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (sw_rd_en),
      .rd_addr (SW_AW'(1)),
      .rd_data (sw_hi),
      .wr_en   (sw_wr_en),
      .wr_addr (info.row_address[SW_AW-1:0]),
      .wr_data (req_bus.column_sense)
   );

   always_comb begin
      s1_in.opcode        = req_bus.opcode;
      s1_in.row_index     = req_bus.row_index;
      s1_in.write_data    = req_bus.write_data;
      s1_in.write_mask    = req_bus.write_mask;
      s1_in.row_address   = info.row_address;
      s1_in.led_enable    = info.led_enable;
      s1_in.columns_drive = info.columns_drive;
      s1_in.latch_row     = is_tick && info.latch_row;
      s1_valid_in         = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
   end

   assign level_val  = s1_ff.latch_row ? led_old : latched_ff;
   assign latched_in = commit ? level_val : latched_ff;

   always_comb begin
      for (int i = 0; i < COLUMNS; i++) begin
         level_out[i] = s1_ff.columns_drive && (i < lsms_pkg::LEVEL_BITS) && !level_val[i];
      end
   end

   always_comb begin
      pair_wide = '0;
      read_out  = '0;
      case (s1_ff.opcode)
         lsms_pkg::OP_READ_ROW: begin
            if ({1'b0, s1_ff.row_index} < 4'(SWITCH_ROWS)) begin
               pair_wide = {{(64-COLUMNS){1'b0}}, ~sw_lo};
            end
         end
         lsms_pkg::OP_READ_REG: begin
            pair_wide = {{(64-COLUMNS){1'b0}}, ~sw_lo};
            if (SWITCH_ROWS > 1) begin
               pair_wide = pair_wide | ({{(64-COLUMNS){1'b0}}, ~sw_hi} << COLUMNS);
            end
         end
         default: begin
            pair_wide = '0;
         end
      endcase
      read_out = pair_wide[lsms_pkg::READ_BITS-1:0];
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         latched_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         latched_ff   <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (commit) begin
         rsp_row_ff    <= s1_ff.row_address;
         rsp_led_en_ff <= s1_ff.led_enable;
         rsp_drive_ff  <= s1_ff.columns_drive;
         rsp_level_ff  <= level_out;
         rsp_read_ff   <= read_out;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.row_address   = rsp_row_ff;
   assign rsp_bus.led_enable    = rsp_led_en_ff;
   assign rsp_bus.columns_drive = rsp_drive_ff;
   assign rsp_bus.column_level  = rsp_level_ff;
   assign rsp_bus.read_data     = rsp_read_ff;

`ifndef NO_ASSERTIONS
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("transaction accepted into a blocked pipeline");
   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed transaction missing from response register");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED and switch matrix scanner. Commands come
// from a backlog queue through a clocked driver with random gaps. Each
// accepted command runs through a cycle-free scan predictor. A clocked monitor
// with random stalls checks every response, field by field, in order.
// lit_ticks is rewritten between phases, from zero to full scale.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LED_ROWS    = 7;
   localparam int SWITCH_ROWS = 5;
   localparam int COLUMNS     = 18;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_WAIT    = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int OPCODE_BITS = lsms_pkg::OPCODE_BITS;
   localparam int ROW_BITS    = lsms_pkg::ROW_BITS;
   localparam int TICK_BITS   = lsms_pkg::TICK_BITS;
   localparam int READ_BITS   = lsms_pkg::READ_BITS;
   localparam logic [COLUMNS-1:0] ALL_COLS = '1;

   typedef enum logic [1:0] {
      SCAN_LIT    = 2'd0,
      SCAN_BLANK  = 2'd1,
      SCAN_SWITCH = 2'd2
   } scan_phase_type;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [ROW_BITS-1:0]    row_index;
      logic [COLUMNS-1:0]     write_data;
      logic [COLUMNS-1:0]     write_mask;
      logic [COLUMNS-1:0]     column_sense;
   } panel_cmd_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]  row_address;
      logic                 led_enable;
      logic                 columns_drive;
      logic [COLUMNS-1:0]   column_level;
      logic [READ_BITS-1:0] read_data;
   } panel_pins_type;

   logic clock;
   logic reset;

   lsms_req_if #(.COLUMNS(COLUMNS)) req_bus ();
   lsms_rsp_if #(.COLUMNS(COLUMNS)) rsp_bus ();
   lsms_csr_if                      csr_bus ();

   led_switch_matrix_scanner #(
      .LED_ROWS    (LED_ROWS),
      .SWITCH_ROWS (SWITCH_ROWS),
      .COLUMNS     (COLUMNS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   logic [TICK_BITS-1:0] lit_ticks;
   logic [COLUMNS-1:0]   led_rows [0:7];
   logic [COLUMNS-1:0]   switch_rows [0:7];
   logic [COLUMNS-1:0]   latched_row;
   scan_phase_type       scan_phase;
   logic [ROW_BITS-1:0]  scan_row;
   logic [TICK_BITS-1:0] tick_count;

   panel_cmd_type  cmd_backlog[$];
   panel_pins_type pins_due[$];
   panel_cmd_type  offered;
   panel_pins_type seen_pins;
   panel_pins_type want_pins;

   logic req_fire;
   logic rsp_fire;
   int   req_gap;
   int   rsp_stall;
   int   sent_count;
   int   taken_count;
   int   hold_left;
   int   hold_asks;
   int   hold_seen;
   int   mismatches;
   int   cycle_count;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report(input string what, input logic [READ_BITS-1:0] got,
                         input logic [READ_BITS-1:0] want);
      mismatches++;
      $display("mismatch %s at transaction %0d: got %0h expected %0h",
               what, taken_count, got, want);
   endtask

   function automatic int draw_wait(input int n);
      return ((n / 64) % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void end_led_row();
      scan_row   = scan_row + 1'b1;
      tick_count = '0;
      if (scan_row >= LED_ROWS || scan_row == 0) begin
         scan_row   = '0;
         scan_phase = SCAN_SWITCH;
      end else begin
         scan_phase = SCAN_LIT;
      end
   endfunction

   function automatic panel_pins_type panel_step(input panel_cmd_type c);
      panel_pins_type       outs;
      logic [TICK_BITS-1:0] lit_len;
      logic [TICK_BITS-1:0] blank_len;
      logic [TICK_BITS-1:0] settle_len;
      logic                 drive;
      outs       = '0;
      lit_len    = (lit_ticks != 0) ? lit_ticks : 16'd1;
      blank_len  = lit_ticks >> 1;
      settle_len = TICK_BITS'(lit_ticks / 10);
      if (c.opcode == lsms_pkg::OP_TICK && scan_phase == SCAN_LIT && tick_count == 0 &&
          scan_row < LED_ROWS) begin
         latched_row = led_rows[scan_row];
      end
      drive              = (scan_phase == SCAN_LIT || scan_phase == SCAN_BLANK);
      outs.row_address   = scan_row;
      outs.led_enable    = (scan_phase == SCAN_LIT);
      outs.columns_drive = drive;
      outs.column_level  = drive ? ~latched_row : '0;
      case (c.opcode)
         lsms_pkg::OP_TICK: begin
            if (scan_phase == SCAN_LIT) begin
               tick_count = tick_count + 1'b1;
               if (tick_count >= lit_len) begin
                  tick_count = '0;
                  if (blank_len > 0) begin
                     scan_phase = SCAN_BLANK;
                  end else begin
                     end_led_row();
                  end
               end
            end else if (scan_phase == SCAN_BLANK) begin
               tick_count = tick_count + 1'b1;
               if (tick_count >= blank_len) begin
                  end_led_row();
               end
            end else if (scan_phase == SCAN_SWITCH) begin
               if (tick_count >= settle_len) begin
                  if (scan_row < SWITCH_ROWS) begin
                     switch_rows[scan_row] = c.column_sense;
                  end
                  tick_count = '0;
                  scan_row   = scan_row + 1'b1;
                  if (scan_row >= SWITCH_ROWS || scan_row == 0) begin
                     scan_row   = '0;
                     scan_phase = SCAN_LIT;
                  end
               end else begin
                  tick_count = tick_count + 1'b1;
               end
            end else begin
               scan_phase = SCAN_LIT;
               scan_row   = '0;
               tick_count = '0;
            end
         end
         lsms_pkg::OP_WRITE: begin
            if (c.row_index < LED_ROWS) begin
               led_rows[c.row_index] = (led_rows[c.row_index] & ~c.write_mask) |
                                       (c.write_data & c.write_mask);
            end
         end
         lsms_pkg::OP_READ_ROW: begin
            if (c.row_index < SWITCH_ROWS) begin
               outs.read_data = {{(READ_BITS-COLUMNS){1'b0}}, ~switch_rows[c.row_index]};
            end
         end
         default: begin
            outs.read_data = {~switch_rows[1], ~switch_rows[0]};
         end
      endcase
      return outs;
   endfunction

   task automatic push_cmd(input logic [OPCODE_BITS-1:0] op, input int idx,
                           input logic [COLUMNS-1:0] data, input logic [COLUMNS-1:0] mask,
                           input logic [COLUMNS-1:0] sense);
      panel_cmd_type c;
      c.opcode       = op;
      c.row_index    = ROW_BITS'(idx);
      c.write_data   = data;
      c.write_mask   = mask;
      c.column_sense = sense;
      cmd_backlog.push_back(c);
   endtask

   task automatic push_random_cmd();
      int                 pick;
      logic [COLUMNS-1:0] mask;
      logic [COLUMNS-1:0] sense;
      pick  = $urandom_range(0, 99);
      mask  = ($urandom_range(0, 7) == 0) ? ALL_COLS : COLUMNS'($urandom);
      sense = ($urandom_range(0, 3) == 0) ? ALL_COLS : COLUMNS'($urandom);
      if (pick < 70) begin
         push_cmd(lsms_pkg::OP_TICK, $urandom_range(0, 7), COLUMNS'($urandom),
                  COLUMNS'($urandom), sense);
      end else if (pick < 82) begin
         push_cmd(lsms_pkg::OP_WRITE, $urandom_range(0, 7), COLUMNS'($urandom), mask, sense);
      end else if (pick < 93) begin
         push_cmd(lsms_pkg::OP_READ_ROW, $urandom_range(0, 7), COLUMNS'($urandom), mask,
                  sense);
      end else begin
         push_cmd(lsms_pkg::OP_READ_REG, $urandom_range(0, 7), COLUMNS'($urandom), mask,
                  sense);
      end
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_bus.valid || pins_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_lit_ticks(input logic [TICK_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.lit_ticks <= value;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      lit_ticks = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // driver: acceptance at the rising edge, new transaction at the falling edge
   always @(posedge clock) begin
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         pins_due.push_back(panel_step(offered));
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fire) begin
         req_bus.valid <= 1'b1;
      end else if (req_gap > 0) begin
         req_bus.valid <= 1'b0;
         req_gap--;
      end else if (cmd_backlog.size() != 0) begin
         offered                = cmd_backlog.pop_front();
         req_bus.opcode         <= offered.opcode;
         req_bus.row_index      <= offered.row_index;
         req_bus.write_data     <= offered.write_data;
         req_bus.write_mask     <= offered.write_mask;
         req_bus.column_sense   <= offered.column_sense;
         req_bus.valid          <= 1'b1;
         req_gap                = draw_wait(sent_count);
         sent_count++;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_fire <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         taken_count <= taken_count + 1;
         seen_pins.row_address   = rsp_bus.row_address;
         seen_pins.led_enable    = rsp_bus.led_enable;
         seen_pins.columns_drive = rsp_bus.columns_drive;
         seen_pins.column_level  = rsp_bus.column_level;
         seen_pins.read_data     = rsp_bus.read_data;
         if (pins_due.size() == 0) begin
            report("unexpected response", seen_pins.read_data, '0);
         end else begin
            want_pins = pins_due.pop_front();
            if (seen_pins.row_address !== want_pins.row_address)
               report("row_address", READ_BITS'(seen_pins.row_address),
                      READ_BITS'(want_pins.row_address));
            if (seen_pins.led_enable !== want_pins.led_enable)
               report("led_enable", READ_BITS'(seen_pins.led_enable),
                      READ_BITS'(want_pins.led_enable));
            if (seen_pins.columns_drive !== want_pins.columns_drive)
               report("columns_drive", READ_BITS'(seen_pins.columns_drive),
                      READ_BITS'(want_pins.columns_drive));
            if (seen_pins.column_level !== want_pins.column_level)
               report("column_level", READ_BITS'(seen_pins.column_level),
                      READ_BITS'(want_pins.column_level));
            if (seen_pins.read_data !== want_pins.read_data)
               report("read_data", seen_pins.read_data, want_pins.read_data);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_stall = draw_wait(taken_count + 32);
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_asks;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [TICK_BITS-1:0] lit_settings [0:9];
      int                   phase_items;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = lsms_pkg::OP_TICK;
      req_bus.row_index    = '0;
      req_bus.write_data   = '0;
      req_bus.write_mask   = '0;
      req_bus.column_sense = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.lit_ticks    = '0;
      req_fire             = 1'b0;
      rsp_fire             = 1'b0;
      req_gap              = 0;
      rsp_stall            = 0;
      sent_count           = 0;
      taken_count          = 0;
      hold_asks            = 0;
      hold_seen            = 0;
      mismatches           = 0;
      cycle_count          = 0;
      offered              = '0;
      lit_ticks            = lsms_pkg::LIT_TICKS_RESET;
      latched_row          = '0;
      scan_phase           = SCAN_LIT;
      scan_row             = '0;
      tick_count           = '0;
      for (int i = 0; i < 8; i++) begin
         led_rows[i]    = '0;
         switch_rows[i] = ALL_COLS;
      end
      lit_settings = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd10, 16'd4, 16'd11,
                       16'd20, 16'd0};
      lit_settings[9] = TICK_BITS'($urandom_range(5, 40));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: masks, missing rows, reads after reset, pin extremes
      push_cmd(lsms_pkg::OP_WRITE, 0, ALL_COLS, ALL_COLS, '0);
      push_cmd(lsms_pkg::OP_WRITE, 6, 18'h2AAAA, ALL_COLS, '0);
      push_cmd(lsms_pkg::OP_WRITE, 6, 18'h15555, '0, ALL_COLS);
      push_cmd(lsms_pkg::OP_WRITE, 3, ALL_COLS, 18'h15555, '0);
      push_cmd(lsms_pkg::OP_WRITE, 7, ALL_COLS, ALL_COLS, ALL_COLS);
      push_cmd(lsms_pkg::OP_WRITE, 2, 18'h00001, 18'h20001, '0);
      push_cmd(lsms_pkg::OP_READ_ROW, 0, '0, '0, '0);
      push_cmd(lsms_pkg::OP_READ_ROW, 4, ALL_COLS, ALL_COLS, ALL_COLS);
      push_cmd(lsms_pkg::OP_READ_ROW, 5, '0, '0, '0);
      push_cmd(lsms_pkg::OP_READ_ROW, 7, '0, '0, '0);
      push_cmd(lsms_pkg::OP_READ_REG, 0, '0, '0, '0);
      push_cmd(lsms_pkg::OP_TICK, 0, '0, '0, '0);
      push_cmd(lsms_pkg::OP_TICK, 0, ALL_COLS, ALL_COLS, ALL_COLS);
      push_cmd(lsms_pkg::OP_WRITE, 1, ALL_COLS, 18'h20001, '0);
      push_cmd(lsms_pkg::OP_WRITE, 0, '0, 18'h3FFFE, '0);
      push_cmd(lsms_pkg::OP_READ_REG, 7, ALL_COLS, ALL_COLS, ALL_COLS);
      push_cmd(lsms_pkg::OP_TICK, 5, ALL_COLS, '0, '0);
      wait_drained();

      for (int p = 0; p < 10; p++) begin
         write_lit_ticks(lit_settings[p]);
         phase_items = (lit_settings[p] == 16'hFFFF) ? 40 : 130;
         for (int n = 0; n < phase_items; n++) begin
            push_random_cmd();
         end
         if (lit_settings[p] == 16'd10) begin
            hold_asks = hold_asks + 1;
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (pins_due.size() != 0) begin
         report("responses missing", READ_BITS'(pins_due.size()), '0);
      end
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> led_switch_matrix_scanner.f
hw/rtl/lsms_pkg.sv
hw/rtl/lsms_req_if.sv
hw/rtl/lsms_rsp_if.sv
hw/rtl/lsms_csr_if.sv
hw/rtl/lsms_row_mem.sv
hw/rtl/lsms_scan_ctrl.sv
hw/rtl/led_switch_matrix_scanner.sv
tb/tb_top.sv
